/* rtl/core/tpr_pkg.sv */
// shared types, register codes, operation codes and helper functions
package tpr_pkg;

  localparam int DEF_STORE_DEPTH = 65536;
  localparam int DEF_MAX_WIDTH   = 4096;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int PIX_W      = 32;
  localparam int PERM_BITS  = 16;
  localparam int TILE_MAX   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BPP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CMAP  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERM  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PW    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILE  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd7;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_RANGE  = 2'd1;
  localparam logic [1:0] STAT_NOLOAD = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE   = 5'd0;
  localparam logic [OP_W-1:0] OP_INIT   = 5'd1;
  localparam logic [OP_W-1:0] OP_DLINES = 5'd2;
  localparam logic [OP_W-1:0] OP_DSW    = 5'd3;
  localparam logic [OP_W-1:0] OP_FLIP   = 5'd4;
  localparam logic [OP_W-1:0] OP_CHECK  = 5'd5;
  localparam logic [OP_W-1:0] OP_DN     = 5'd6;
  localparam logic [OP_W-1:0] OP_DXT    = 5'd7;
  localparam logic [OP_W-1:0] OP_DYT    = 5'd8;
  localparam logic [OP_W-1:0] OP_UM1    = 5'd9;
  localparam logic [OP_W-1:0] OP_UM2    = 5'd10;
  localparam logic [OP_W-1:0] OP_UM3    = 5'd11;
  localparam logic [OP_W-1:0] OP_DAREA  = 5'd12;
  localparam logic [OP_W-1:0] OP_DIN    = 5'd13;
  localparam logic [OP_W-1:0] OP_DRT    = 5'd14;
  localparam logic [OP_W-1:0] OP_TM1    = 5'd15;
  localparam logic [OP_W-1:0] OP_TM2    = 5'd16;
  localparam logic [OP_W-1:0] OP_TM3    = 5'd17;
  localparam logic [OP_W-1:0] OP_PERM   = 5'd18;
  localparam logic [OP_W-1:0] OP_READ   = 5'd19;
  localparam logic [OP_W-1:0] OP_OUT    = 5'd20;
  localparam logic [OP_W-1:0] OP_NL     = 5'd21;

  typedef struct packed {
    logic [2:0]  bpp;
    logic [12:0] width;
    logic [16:0] count;
    logic [7:0]  cmap;
    logic [63:0] perm;
    logic [4:0]  pw;
    logic [4:0]  tile;
    logic [1:0]  mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{bpp: 3'd4, width: 13'd256, count: 17'd65536, cmap: 8'd228,
                                 perm: 64'd0, pw: 5'd0, tile: 5'd0, mode: 2'd0};

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            start;
    logic            load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic loaded;
    logic out_free;
    logic flip;
    logic pack;
    logic tile_on;
  } status_t;

  function automatic logic [PERM_BITS-1:0] perm_low(input logic [PERM_BITS-1:0] p,
                                                   input logic [63:0] map,
                                                   input logic [4:0] w);
    logic [PERM_BITS-1:0] low;
    logic [PERM_BITS:0]   mask;
    low  = '0;
    mask = (17'd1 << w) - 17'd1;
    for (int j = 0; j < PERM_BITS; j++) begin
      if ((5'(j) < w) && p[j]) begin
        low[map[4*j +: 4]] = 1'b1;
      end
    end
    return (p & ~mask[PERM_BITS-1:0]) | (low & mask[PERM_BITS-1:0]);
  endfunction

  function automatic logic [PIX_W-1:0] swizzle(input logic [PIX_W-1:0] v,
                                               input logic [7:0] cmap);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = v[8*cmap[2*k +: 2] +: 8];
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] bpp_mask(input logic [2:0] bpp);
    logic [PIX_W-1:0] m;
    unique case (bpp)
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/tpr_div.sv */
// iterative restoring divider, one quotient bit per cycle
module tpr_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem_r[W-1:0], quo_r[W-1]};
    if (shifted >= {1'b0, divisor}) begin
      rem_nxt = shifted - {1'b0, divisor};
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[W-1:0];

endmodule

/* rtl/core/tpr_datapath.sv */
// address mapping datapath, pixel store, positions and result register
module tpr_datapath #(
  parameter int STORE_DEPTH = tpr_pkg::DEF_STORE_DEPTH,
  parameter int MAX_WIDTH   = tpr_pkg::DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tpr_pkg::cfg_t          cfg,
  input  tpr_pkg::cmd_t          cmd,
  output tpr_pkg::status_t       status,
  input  logic [31:0]            in_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            out_pixel,
  output logic                   out_last,
  output logic [1:0]             out_status
);
  import tpr_pkg::*;

  localparam int AW  = $clog2(STORE_DEPTH) + 1;
  localparam int MW  = $clog2(STORE_DEPTH);
  localparam int WW  = $clog2(MAX_WIDTH) + 1;
  localparam int IW0 = (AW > WW + 5) ? AW : WW + 5;
  localparam int IW  = ((IW0 > PERM_BITS) ? IW0 : PERM_BITS) + 2;

  logic [PIX_W-1:0] mem [STORE_DEPTH];

  logic [AW-1:0] cnt_e, load_pos_r, fetch_pos_r;
  logic [WW-1:0] w_e;
  logic [4:0]    t_e, pw_e;
  logic [2:0]    bpp_e;
  logic [IW-1:0] cnt_i, w_i, t_i, area_i;

  logic [IW-1:0] s_r, y_r, x_r, u_r, v_r, g_r, h_r, a_r, b_r, lines_r, n_r;
  logic          ok_r;
  logic [PIX_W-1:0] rd_data_r;

  logic [IW-1:0] div_a, div_b, div_q, div_r;
  logic          div_done;

  logic          out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic [1:0]    out_status_r;
  logic          out_free, last_pix, out_load;

  always_comb begin
    if (cfg.count == '0)                         cnt_e = AW'(1);
    else if (32'(cfg.count) > 32'(STORE_DEPTH))  cnt_e = AW'(STORE_DEPTH);
    else                                         cnt_e = AW'(cfg.count);
    if (cfg.width == '0)                         w_e = WW'(1);
    else if (32'(cfg.width) > 32'(MAX_WIDTH))    w_e = WW'(MAX_WIDTH);
    else                                         w_e = WW'(cfg.width);
    t_e   = (cfg.tile > 5'(TILE_MAX)) ? 5'(TILE_MAX) : cfg.tile;
    pw_e  = (cfg.pw > 5'(PERM_BITS)) ? 5'(PERM_BITS) : cfg.pw;
    bpp_e = (cfg.bpp < 3'd2) ? 3'd2 : ((cfg.bpp > 3'd4) ? 3'd4 : cfg.bpp);
  end

  assign cnt_i  = IW'(cnt_e);
  assign w_i    = IW'(w_e);
  assign t_i    = IW'(t_e);
  assign area_i = IW'(t_e) * IW'(t_e);

  always_comb begin
    div_a = s_r;
    div_b = w_i;
    unique case (cmd.op)
      OP_DLINES: begin div_a = cnt_i; div_b = w_i;    end
      OP_DN:     begin div_a = w_i;   div_b = t_i;    end
      OP_DXT:    begin div_a = x_r;   div_b = t_i;    end
      OP_DRT:    begin div_a = x_r;   div_b = t_i;    end
      OP_DYT:    begin div_a = y_r;   div_b = t_i;    end
      OP_DAREA:  begin div_a = s_r;   div_b = area_i; end
      OP_DIN:    begin div_a = y_r;   div_b = n_r;    end
      default:   begin div_a = s_r;   div_b = w_i;    end
    endcase
  end

  tpr_div #(.W(IW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && ((cmd.op == OP_OUT) || (cmd.op == OP_NL));
  assign last_pix = fetch_pos_r >= (cnt_e - AW'(1));

  always_ff @(posedge clk) begin
    if (div_done) begin
      unique case (cmd.op)
        OP_DLINES: lines_r <= div_q;
        OP_DSW:    begin y_r <= div_q; x_r <= div_r; end
        OP_DN:     n_r <= div_q;
        OP_DXT:    begin u_r <= div_q; v_r <= div_r; end
        OP_DRT:    begin u_r <= div_q; v_r <= div_r; end
        OP_DYT:    begin g_r <= div_q; h_r <= div_r; end
        OP_DAREA:  begin y_r <= div_q; x_r <= div_r; end
        OP_DIN:    begin g_r <= div_q; h_r <= div_r; end
        default:   ;
      endcase
    end
    unique case (cmd.op)
      OP_INIT: s_r <= IW'(fetch_pos_r);
      OP_FLIP: s_r <= IW'((lines_r - IW'(1) - y_r) * w_i + x_r);
      OP_UM1:  a_r <= IW'(g_r * n_r + u_r);
      OP_UM2:  a_r <= IW'(a_r * t_i + h_r);
      OP_UM3:  s_r <= IW'(a_r * t_i + v_r);
      OP_TM1:  a_r <= IW'(g_r * t_i + u_r);
      OP_TM2:  b_r <= IW'(h_r * t_i + v_r);
      OP_TM3:  s_r <= IW'(a_r * w_i + b_r);
      OP_PERM: s_r <= {s_r[IW-1:PERM_BITS], perm_low(s_r[PERM_BITS-1:0], cfg.perm, pw_e)};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (load_pos_r < cnt_e)) begin
      mem[load_pos_r[MW-1:0]] <= in_pixel & bpp_mask(bpp_e);
    end
    rd_data_r <= mem[s_r[MW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r        <= 1'b0;
      load_pos_r  <= '0;
      fetch_pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && (load_pos_r < cnt_e)) begin
        load_pos_r <= load_pos_r + AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (div_done) begin
        priority case (cmd.op)
          OP_DN:   ok_r <= ok_r && (div_q != '0);
          OP_DXT:  ok_r <= ok_r && (div_q < n_r);
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_INIT:  ok_r <= fetch_pos_r < cnt_e;
        OP_FLIP:  ok_r <= ok_r && (y_r < lines_r);
        OP_CHECK: ok_r <= ok_r && (s_r < cnt_i);
        OP_OUT: begin
          if (out_free) begin
            if (last_pix) begin
              fetch_pos_r <= '0;
              load_pos_r  <= '0;
            end else begin
              fetch_pos_r <= fetch_pos_r + AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (cmd.op == OP_OUT) begin
        out_pixel_r  <= !ok_r ? '0 : ((bpp_e == 3'd4) ? swizzle(rd_data_r, cfg.cmap)
                                                       : rd_data_r);
        out_last_r   <= last_pix;
        out_status_r <= ok_r ? STAT_OK : STAT_RANGE;
      end else if (cmd.op == OP_NL) begin
        out_pixel_r  <= '0;
        out_last_r   <= 1'b0;
        out_status_r <= STAT_NOLOAD;
      end
    end
  end

  assign status.div_done = div_done;
  assign status.loaded   = load_pos_r >= cnt_e;
  assign status.out_free = out_free;
  assign status.flip     = cfg.mode[0];
  assign status.pack     = cfg.mode[1];
  assign status.tile_on  = t_e != '0;

  assign out_valid  = out_valid_r;
  assign out_pixel  = out_pixel_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

/* rtl/core/tpr_ctrl.sv */
// sequencer for load and fetch requests
module tpr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  logic             in_func,
  input  tpr_pkg::status_t status,
  output tpr_pkg::cmd_t    cmd,
  output logic             busy
);
  import tpr_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_FLN   = 5'd2;
  localparam logic [4:0] S_FSW   = 5'd3;
  localparam logic [4:0] S_FFL   = 5'd4;
  localparam logic [4:0] S_FCK   = 5'd5;
  localparam logic [4:0] S_UN    = 5'd6;
  localparam logic [4:0] S_USW   = 5'd7;
  localparam logic [4:0] S_UXT   = 5'd8;
  localparam logic [4:0] S_UYT   = 5'd9;
  localparam logic [4:0] S_UM1   = 5'd10;
  localparam logic [4:0] S_UM2   = 5'd11;
  localparam logic [4:0] S_UM3   = 5'd12;
  localparam logic [4:0] S_UCK   = 5'd13;
  localparam logic [4:0] S_TN    = 5'd14;
  localparam logic [4:0] S_TAR   = 5'd15;
  localparam logic [4:0] S_TIN   = 5'd16;
  localparam logic [4:0] S_TRT   = 5'd17;
  localparam logic [4:0] S_TM1   = 5'd18;
  localparam logic [4:0] S_TM2   = 5'd19;
  localparam logic [4:0] S_TM3   = 5'd20;
  localparam logic [4:0] S_TCK   = 5'd21;
  localparam logic [4:0] S_PRM   = 5'd22;
  localparam logic [4:0] S_PCK   = 5'd23;
  localparam logic [4:0] S_RD    = 5'd24;
  localparam logic [4:0] S_OUT   = 5'd25;
  localparam logic [4:0] S_NL    = 5'd26;

  logic [4:0] state_r, state_nxt;
  logic       wait_r, wait_nxt;
  logic       is_div;
  logic [OP_W-1:0] op;

  always_comb begin
    is_div = 1'b0;
    unique case (state_r)
      S_INIT:  op = OP_INIT;
      S_FLN:   begin op = OP_DLINES; is_div = 1'b1; end
      S_FSW:   begin op = OP_DSW;    is_div = 1'b1; end
      S_FFL:   op = OP_FLIP;
      S_UN:    begin op = OP_DN;     is_div = 1'b1; end
      S_USW:   begin op = OP_DSW;    is_div = 1'b1; end
      S_UXT:   begin op = OP_DXT;    is_div = 1'b1; end
      S_UYT:   begin op = OP_DYT;    is_div = 1'b1; end
      S_UM1:   op = OP_UM1;
      S_UM2:   op = OP_UM2;
      S_UM3:   op = OP_UM3;
      S_TN:    begin op = OP_DN;     is_div = 1'b1; end
      S_TAR:   begin op = OP_DAREA;  is_div = 1'b1; end
      S_TIN:   begin op = OP_DIN;    is_div = 1'b1; end
      S_TRT:   begin op = OP_DRT;    is_div = 1'b1; end
      S_TM1:   op = OP_TM1;
      S_TM2:   op = OP_TM2;
      S_TM3:   op = OP_TM3;
      S_PRM:   op = OP_PERM;
      S_FCK, S_UCK, S_TCK, S_PCK: op = OP_CHECK;
      S_RD:    op = OP_READ;
      S_OUT:   op = OP_OUT;
      S_NL:    op = OP_NL;
      default: op = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    if (is_div) begin
      wait_nxt = 1'b1;
      if (status.div_done) begin
        wait_nxt = 1'b0;
      end
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_FETCH)) begin
          state_nxt = status.loaded ? S_INIT : S_NL;
        end
      end
      S_INIT: begin
        if (status.pack)         state_nxt = S_PRM;
        else if (status.flip)    state_nxt = S_FLN;
        else if (status.tile_on) state_nxt = S_UN;
        else                     state_nxt = S_PRM;
      end
      S_FLN: if (status.div_done) state_nxt = S_FSW;
      S_FSW: if (status.div_done) state_nxt = S_FFL;
      S_FFL: state_nxt = S_FCK;
      S_FCK: begin
        if (status.pack)         state_nxt = S_RD;
        else if (status.tile_on) state_nxt = S_UN;
        else                     state_nxt = S_PRM;
      end
      S_UN:  if (status.div_done) state_nxt = S_USW;
      S_USW: if (status.div_done) state_nxt = S_UXT;
      S_UXT: if (status.div_done) state_nxt = S_UYT;
      S_UYT: if (status.div_done) state_nxt = S_UM1;
      S_UM1: state_nxt = S_UM2;
      S_UM2: state_nxt = S_UM3;
      S_UM3: state_nxt = S_UCK;
      S_UCK: state_nxt = S_PRM;
      S_TN:  if (status.div_done) state_nxt = S_TAR;
      S_TAR: if (status.div_done) state_nxt = S_TIN;
      S_TIN: if (status.div_done) state_nxt = S_TRT;
      S_TRT: if (status.div_done) state_nxt = S_TM1;
      S_TM1: state_nxt = S_TM2;
      S_TM2: state_nxt = S_TM3;
      S_TM3: state_nxt = S_TCK;
      S_TCK: state_nxt = status.flip ? S_FLN : S_RD;
      S_PRM: state_nxt = S_PCK;
      S_PCK: begin
        if (!status.pack)        state_nxt = S_RD;
        else if (status.tile_on) state_nxt = S_TN;
        else if (status.flip)    state_nxt = S_FLN;
        else                     state_nxt = S_RD;
      end
      S_RD:  state_nxt = S_OUT;
      S_OUT: if (status.out_free) state_nxt = S_IDLE;
      S_NL:  if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign cmd.op    = op;
  assign cmd.start = is_div && !wait_r;
  assign cmd.load  = (state_r == S_IDLE) && in_acc && (in_func == FUNC_LOAD);
  assign busy      = state_r != S_IDLE;

endmodule

/* rtl/core/texture_pixel_reorder_engine.sv */
// top level: texture pixel reorder engine with configuration registers
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall    in_func, in_pixel_in
//   out_     output     out_valid / out_stall  out_pixel_out, out_last, out_status
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a load request is taken without leaving the idle state; a fetch steps through the
// sequencer states of its mode, the serial divider working out rows, tiles and offsets
// one bit a cycle; IW, the divider's internal index width, is 20 at the default sizes.
// reset clears the sequencer, positions and output valid flag and loads the default
// configuration; the pixel store holds no reset. a stalled result stays in the output
// register while the next request is accepted and worked on; its result waits for it.
module texture_pixel_reorder_engine #(
  parameter int STORE_DEPTH = tpr_pkg::DEF_STORE_DEPTH,
  parameter int MAX_WIDTH   = tpr_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [31:0]                    in_pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_pixel_out,
  output logic                           out_last,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpr_pkg::*;

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;
  logic    busy, in_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BPP:   cfg_r.bpp   <= cfg_data[2:0];
        REG_WIDTH: cfg_r.width <= cfg_data[12:0];
        REG_COUNT: cfg_r.count <= cfg_data[16:0];
        REG_CMAP:  cfg_r.cmap  <= cfg_data[7:0];
        REG_PERM:  cfg_r.perm  <= cfg_data;
        REG_PW:    cfg_r.pw    <= cfg_data[4:0];
        REG_TILE:  cfg_r.tile  <= cfg_data[4:0];
        REG_MODE:  cfg_r.mode  <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  tpr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_func (in_func),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  tpr_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .status     (status),
    .in_pixel   (in_pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel_out),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule
